// File: design/rmq_pkg.sv
// Shared constants for the rotation matrix to quaternion core.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;
  localparam int unsigned ElemW = 16;
  localparam int unsigned MagW  = 15;
  localparam logic [MagW-1:0] MagMax = 15'h7fff;
endpackage
`default_nettype wire

// File: design/rmq_sqrt_pipe.sv
// Pipelined floor square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt_pipe #(
  parameter int unsigned InW = 48
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [InW-1:0]       rad_i,
  output logic [(InW+1)/2-1:0] root_o
);
  localparam int unsigned RootW = (InW + 1) / 2;
  localparam int unsigned PadW  = 2 * RootW;
  localparam int unsigned RemW  = RootW + 2;

  logic [PadW-1:0]  rad_q  [RootW+1];
  logic [RemW-1:0]  rem_q  [RootW+1];
  logic [RootW-1:0] root_q [RootW+1];

  always_comb begin
    rad_q[0]  = PadW'(rad_i);
    rem_q[0]  = '0;
    root_q[0] = '0;
  end

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    logic [RemW-1:0]  trial;
    logic [RemW-1:0]  cur;
    logic [PadW-1:0]  rad_d;
    logic [RemW-1:0]  rem_d;
    logic [RootW-1:0] root_d;
    always_comb begin
      cur    = {rem_q[s][RemW-3:0], rad_q[s][PadW-1 -: 2]};
      trial  = {root_q[s], 2'b01};
      rad_d  = {rad_q[s][PadW-3:0], 2'b00};
      if (cur >= trial) begin
        rem_d  = cur - trial;
        root_d = {root_q[s][RootW-2:0], 1'b1};
      end else begin
        rem_d  = cur;
        root_d = {root_q[s][RootW-2:0], 1'b0};
      end
    end
    logic [PadW-1:0]  rad_r;
    logic [RemW-1:0]  rem_r;
    logic [RootW-1:0] root_r;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_r  <= rad_d;
        rem_r  <= rem_d;
        root_r <= root_d;
      end
    end
    always_comb begin
      rad_q[s+1]  = rad_r;
      rem_q[s+1]  = rem_r;
      root_q[s+1] = root_r;
    end
  end

  assign root_o = root_q[RootW];
endmodule
`default_nettype wire

// File: design/rotation_matrix_to_quaternion_core.sv
// Top level of the rotation matrix to unit quaternion core.
//
//  channel | dir | tdata fields (low bit up)
//  s_axis  | in  | xaxis_x..zaxis_z, nine 16-bit signed Q2.14 (144 bits)
//  m_axis  | out | quat_scalar 15b, quat_x/y/z 16b signed (64 bits, 1 pad bit)
//
// Pipeline from an accepted request to a valid result: input register,
// radicand stage, RootW square root stages (one result bit each) and the
// output register. One request per cycle sustained while the sink does not stall.
// Reset clears only valid bits. A stall freezes the entire pipeline: it
// advances only when its last stage is empty or the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_core
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [143:0] s_axis_tdata,  // xaxis_x,y,z, yaxis_x,y,z, zaxis_x,y,z
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata   // quat_scalar, quat_x, quat_y, quat_z, 0
);
  // root argument: |m_rr - others| < 2^17 plus ONE, kept signed
  localparam int unsigned ArgW   = (FRAC_BITS > 17) ? FRAC_BITS + 2 : 19;
  // radicand: positive argument shifted by FRAC_BITS-2, never narrower than
  // what a saturated magnitude needs
  localparam int unsigned RadRaw = ArgW + FRAC_BITS + 1;
  localparam int unsigned RadW   = (RadRaw > 2 * MagW) ? RadRaw : 2 * MagW;
  localparam int unsigned RootW  = (RadW + 1) / 2;
  localparam int unsigned Depth  = RootW + 3;

  logic [Depth-1:0] vld_q;
  logic             en;
  assign en            = !vld_q[Depth-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
  end

  // stage 1: register inputs
  logic signed [ElemW-1:0] m_q [9];
  always_ff @(posedge clk_i) begin
    if (en) for (int n = 0; n < 9; n++) m_q[n] <= s_axis_tdata[n*ElemW +: ElemW];
  end

  // stage 2: trace, radicands, sign terms
  logic signed [ArgW-1:0] tr, arg [4];
  logic [RadW-1:0] rad_q [4];
  logic signed [17:0] diff_d [3], sum_d [3][2];
  logic diffneg_q [3], sjz_q [3], sjn_q [3], skz_q [3], skn_q [3];
  always_comb begin
    tr = ArgW'(m_q[0]) + ArgW'(m_q[4]) + ArgW'(m_q[8]);
    for (int r = 0; r < 3; r++)
      arg[r] = ArgW'(m_q[r*4]) * ArgW'(2) + (ArgW'(1) <<< FRAC_BITS) - tr;
    arg[3] = (ArgW'(1) <<< FRAC_BITS) + tr;
    for (int i = 0; i < 3; i++) begin
      diff_d[i] = 18'(m_q[((i+1)%3)*3 + (i+2)%3]) - 18'(m_q[((i+2)%3)*3 + (i+1)%3]);
      sum_d[i][0] = 18'(m_q[i*3 + (i+1)%3]) + 18'(m_q[((i+1)%3)*3 + i]);
      sum_d[i][1] = 18'(m_q[i*3 + (i+2)%3]) + 18'(m_q[((i+2)%3)*3 + i]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++)
        rad_q[r] <= (arg[r] <= 0) ? '0 : (RadW'(arg[r]) << (FRAC_BITS - 2));
      for (int i = 0; i < 3; i++) begin
        diffneg_q[i] <= diff_d[i] < 0;
        sjz_q[i] <= sum_d[i][0] == 0;
        sjn_q[i] <= sum_d[i][0] < 0;
        skz_q[i] <= sum_d[i][1] == 0;
        skn_q[i] <= sum_d[i][1] < 0;
      end
    end
  end

  // sign bits travel alongside the roots
  logic [14:0] sgn_q [RootW+1];
  always_comb begin
    for (int i = 0; i < 3; i++)
      sgn_q[0][i*5 +: 5] = {diffneg_q[i], sjz_q[i], sjn_q[i], skz_q[i], skn_q[i]};
  end
  for (genvar s = 0; s < RootW; s++) begin : g_sgn
    logic [14:0] r;
    always_ff @(posedge clk_i) if (en) r <= sgn_q[s];
    assign sgn_q[s+1] = r;
  end

  logic [RootW-1:0] root [4];
  for (genvar r = 0; r < 4; r++) begin : g_sqrt
    rmq_sqrt_pipe #(.InW(RadW)) u_sqrt (
      .clk_i (clk_i), .en_i (en), .rad_i (rad_q[r]), .root_o (root[r])
    );
  end

  // final stage: pick largest, saturate, apply signs
  function automatic logic [MagW-1:0] sat(input logic [RootW-1:0] v);
    return (v > RootW'(MagMax)) ? MagMax : v[MagW-1:0];
  endfunction
  logic [1:0] pick;
  logic [4:0] sg;
  logic neg [3];
  logic negi, negj, negk;
  logic nz;
  logic [15:0] q [3];
  always_comb begin
    pick = 2'd0;
    if (root[1] > root[0]) pick = 2'd1;
    if (root[2] > root[pick]) pick = 2'd2;
    sg = sgn_q[RootW][pick*5 +: 5];
    nz = root[pick] != '0;
    negi = sg[4];
    negj = nz && !sg[3] && (sg[2] != sg[4]);
    negk = nz && !sg[1] && (sg[0] != sg[4]);
    // rotate the picked part and its two followers back to x, y, z
    case (pick)
      2'd1: begin
        neg[0] = negk;
        neg[1] = negi;
        neg[2] = negj;
      end
      2'd2: begin
        neg[0] = negj;
        neg[1] = negk;
        neg[2] = negi;
      end
      default: begin
        neg[0] = negi;
        neg[1] = negj;
        neg[2] = negk;
      end
    endcase
    for (int r = 0; r < 3; r++)
      q[r] = neg[r] ? 16'(16'd0 - {1'b0, sat(root[r])}) : {1'b0, sat(root[r])};
  end
  logic [63:0] out_q;
  always_ff @(posedge clk_i) begin
    if (en) out_q <= {1'b0, q[2], q[1], q[0], sat(root[3])};
  end
  assign m_axis_tdata = out_q;

  // Hold the result steady while the sink stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
  // Accept a request whenever the output stage is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready);
  // Keep the pad bit clear on every result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[63]);
  assert property (@(posedge clk_i) disable iff (!rst_ni) !$isunknown(m_axis_tvalid));
endmodule
`default_nettype wire

// File: sim/rmq_checker.sv
// Checker for the rotation matrix to quaternion core: predicts and compares results.
`timescale 1ns / 1ps
module rmq_checker
  import rmq_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o,
  output int unsigned  quat_seen_o
);
  localparam int unsigned FracBits = 14;

  typedef struct packed {
    logic [15:0]     qz;
    logic [15:0]     qy;
    logic [15:0]     qx;
    logic [MagW-1:0] qs;
  } quat_t;

  quat_t expected_quats[$];
  int unsigned fail_count = 0;
  int unsigned quat_seen = 0;
  int unsigned pending = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign quat_seen_o  = quat_seen;

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned quarter_root(longint arg);
    if (arg <= 0) return 0;
    return floor_sqrt(longint'(arg) << (FracBits - 2));
  endfunction

  function automatic longint unsigned clip_mag(longint unsigned m);
    return (m > MagMax) ? longint'(MagMax) : m;
  endfunction

  function automatic quat_t matrix_to_quat(logic [143:0] d);
    longint el[3][3];
    longint unsigned mag[3];
    logic neg[3];
    longint one, tr, diff, sj, sk;
    longint unsigned v;
    int i, j, k;
    logic [15:0] part[3];
    quat_t q;
    one = longint'(1) << FracBits;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        el[r][c] = longint'($signed(d[(r*3+c)*16 +: 16]));
    tr = el[0][0] + el[1][1] + el[2][2];
    for (int r = 0; r < 3; r++) mag[r] = quarter_root(2 * el[r][r] + one - tr);
    i = 0;
    if (mag[1] > mag[i]) i = 1;
    if (mag[2] > mag[i]) i = 2;
    j = (i + 1) % 3;
    k = (i + 2) % 3;
    diff = el[j][k] - el[k][j];
    sj = el[i][j] + el[j][i];
    sk = el[i][k] + el[k][i];
    neg[i] = diff < 0;
    neg[j] = (mag[i] != 0) && (sj != 0) && ((sj < 0) != neg[i]);
    neg[k] = (mag[i] != 0) && (sk != 0) && ((sk < 0) != neg[i]);
    for (int r = 0; r < 3; r++) begin
      v = clip_mag(mag[r]);
      if (neg[r]) v = 64'd0 - v;
      part[r] = v[15:0];
    end
    q.qs = MagW'(clip_mag(quarter_root(one + tr)));
    q.qx = part[0];
    q.qy = part[1];
    q.qz = part[2];
    return q;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s at %0t: got %0h want %0h", what, $realtime, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    quat_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) expected_quats.push_back(matrix_to_quat(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = quat_t'(m_axis_tdata[62:0]);
        quat_seen++;
        if (expected_quats.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[31:0], 0);
        end else begin
          want = expected_quats.pop_front();
          if (got.qs != want.qs) report_mismatch("quat_scalar", 32'(got.qs), 32'(want.qs));
          if (got.qx != want.qx) report_mismatch("quat_x", 32'(got.qx), 32'(want.qx));
          if (got.qy != want.qy) report_mismatch("quat_y", 32'(got.qy), 32'(want.qy));
          if (got.qz != want.qz) report_mismatch("quat_z", 32'(got.qz), 32'(want.qz));
        end
      end
      pending = expected_quats.size();
    end
  end
endmodule

// File: sim/tb_rotation_matrix_to_quaternion_core.sv
// Testbench top: drives matrices into the quaternion core and gives the verdict.
`timescale 1ns / 1ps
module tb_rotation_matrix_to_quaternion_core;
  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  int unsigned  fail_count, pending, quat_seen;
  logic         calm = 1'b0;    // stretch with no idling on either side
  int unsigned  sent = 0;

  rotation_matrix_to_quaternion_core DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  rmq_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending), .quat_seen_o(quat_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the receiver in about 30 percent of cycles, except during the calm stretch.
  always @(posedge clk_i) m_axis_tready <= calm || ($urandom_range(99) >= 30);

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      3: return 16'($urandom);       // any bit pattern, out of range too
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  // Rough rotation: signed permutation matrix with jitter on every element.
  function automatic logic [143:0] near_rotation();
    logic [143:0] d;
    int perm[3];
    int a, tmp;
    perm = '{0, 1, 2};
    for (int n = 2; n > 0; n--) begin
      a = $urandom_range(n);
      tmp = perm[n]; perm[n] = perm[a]; perm[a] = tmp;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        d[(r*3+c)*16 +: 16] = 16'(((perm[r] == c) ? ($urandom_range(1) ? 16000 : -16000) : 0)
                                  + int'($urandom_range(800)) - 400);
    return d;
  endfunction

  task automatic send_matrix(logic [143:0] d);
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    // Idle the sender now and then; valid stays high for back-to-back requests.
    if (!calm && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3) + 1) @(posedge clk_i);
    end
  endtask

  function automatic logic [143:0] diag(int a, int b, int c);
    logic [143:0] d;
    d = '0;
    d[0 +: 16] = 16'(a); d[64 +: 16] = 16'(b); d[128 +: 16] = 16'(c);
    return d;
  endfunction

  initial begin
    logic [143:0] d;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity, half turns about each axis (ties and zero roots),
    // all-zero, all extremes, sign cases with zero differences and sums.
    send_matrix(diag(16384, 16384, 16384));
    send_matrix(diag(16384, -16384, -16384));
    send_matrix(diag(-16384, 16384, -16384));
    send_matrix(diag(-16384, -16384, 16384));
    send_matrix(diag(-16384, -16384, -16384));
    send_matrix('0);
    send_matrix({9{16'sd16384}});
    send_matrix({9{-16'sd16384}});
    send_matrix({9{16'h8000}});
    send_matrix({9{16'h7fff}});
    send_matrix({9{16'hffff}});
    // 90 degree turns about z and y, both directions, then the z pair with zaxis_z zero
    send_matrix({16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0, 16'd16384, 16'd0});
    send_matrix({16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, -16'sd16384, 16'd0});
    send_matrix({16'd0, 16'd0, 16'd16384, 16'd0, 16'd16384, 16'd0, -16'sd16384, 16'd0, 16'd0});
    send_matrix({16'd0, 16'd0, -16'sd16384, 16'd0, 16'd16384, 16'd0, 16'd16384, 16'd0, 16'd0});
    send_matrix({16'd0, 16'd0, 16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0, 16'd16384, 16'd0});
    send_matrix({16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, -16'sd16384, 16'd0});

    // Random: mostly near rotations, the rest raw fields; calm stretch in the middle.
    for (int n = 0; n < 1950; n++) begin
      calm <= (n >= 800 && n < 1000);
      if ($urandom_range(99) < 60) begin
        d = near_rotation();
      end else begin
        for (int e = 0; e < 9; e++) d[e*16 +: 16] = rand_elem();
      end
      send_matrix(d);
    end
    s_axis_tvalid <= 1'b0;
    calm <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d matrices (directed extremes, near rotations, raw fields),", sent);
    $display("checked %0d quaternions under random stalls on both sides.", quat_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
